// File: rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define IBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequence checked in the cycle after the trigger
`define IBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/iba_pkg.sv
`default_nettype none

package iba_pkg;

  localparam int FuncW   = 2;
  localparam int FileIdW = 16;
  localparam int StatusW = 3;
  localparam int InoOutW = 4;
  localparam int BlkOutW = 8;
  localparam int NumBlkW = 9;

  localparam logic [NumBlkW-1:0] NumBlkRst = 9'd256;
  localparam int FirstDataBlk  = 2;
  localparam int DefInodeCount = 16;
  localparam int DefBlockCount = 256;

  typedef enum logic [FuncW-1:0] {
    FN_CREATE = 2'd0,
    FN_DELETE = 2'd1,
    FN_LOOKUP = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_INODE  = 3'd3,
    ST_NO_BLOCK  = 3'd4
  } status_e;

endpackage

`default_nettype wire

// File: rtl/core/inode_and_block_allocator.sv
`default_nettype none
// channel    | handshake          | payload
// request    | start, busy        | func_i, file_id_i
// result     | done_o (strobe)    | status_o, inode_index_o, block_index_o
// config     | cfg_we_i           | cfg_wdata_i (num_blocks)
//
// after reset the block map is cleared, one entry a cycle, with busy high.
// every request scans the inode table, one entry a cycle through its single read port:
// the strobe ends delete, lookup and a failed create once the last entry has been checked.
// a create that reaches the block map goes on to read the block flags from block 2 up to
// block min(num_blocks, BLOCK_COUNT) - 1 and takes the first free one. busy stays high
// until the strobe; the result is valid only with the strobe, which is high for one cycle.
module inode_and_block_allocator #(
  parameter int INODE_COUNT = iba_pkg::DefInodeCount,
  parameter int BLOCK_COUNT = iba_pkg::DefBlockCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [iba_pkg::FuncW-1:0]    func_i,
  input  logic [iba_pkg::FileIdW-1:0]  file_id_i,
  input  logic                         cfg_we_i,
  input  logic [iba_pkg::NumBlkW-1:0]  cfg_wdata_i,
  output logic                         done_o,
  output logic [iba_pkg::StatusW-1:0]  status_o,
  output logic [iba_pkg::InoOutW-1:0]  inode_index_o,
  output logic [iba_pkg::BlkOutW-1:0]  block_index_o
);
  import iba_pkg::*;

  localparam int InoW    = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
  localparam int InoCntW = $clog2(INODE_COUNT + 1);
  localparam int BlkW    = $clog2(BLOCK_COUNT);
  localparam int BlkCntW = $clog2(BLOCK_COUNT + 1);
  localparam int CmpW    = (BlkCntW > NumBlkW) ? BlkCntW : NumBlkW;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_INO  = 2'd2;
  localparam logic [1:0] S_BLK  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [NumBlkW-1:0]     num_blocks_q, num_blocks_d;
  logic [FuncW-1:0]       func_q, func_d;
  logic [FileIdW-1:0]     id_q, id_d;
  logic [InoCntW-1:0]     ia_q, ia_d;
  logic                   ichk_v_q, ichk_v_d;
  logic [InoW-1:0]        ichk_idx_q, ichk_idx_d;
  logic                   match_q, match_d;
  logic [InoW-1:0]        match_idx_q, match_idx_d;
  logic [BlkW-1:0]        match_blk_q, match_blk_d;
  logic                   free_q, free_d;
  logic [InoW-1:0]        free_idx_q, free_idx_d;
  logic [BlkCntW-1:0]     ba_q, ba_d;
  logic                   bchk_v_q, bchk_v_d;
  logic [BlkW-1:0]        bchk_idx_q, bchk_idx_d;
  logic [INODE_COUNT-1:0] in_use_q, in_use_d;
  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic [InoOutW-1:0]     ino_q, ino_d;
  logic [BlkOutW-1:0]     blk_q, blk_d;

  logic [FileIdW-1:0] ino_id_mem [INODE_COUNT];
  logic [BlkW-1:0]    ino_blk_mem [INODE_COUNT];
  logic               blk_mem [BLOCK_COUNT];
  logic [FileIdW-1:0] ino_id_rd_q;
  logic [BlkW-1:0]    ino_blk_rd_q;
  logic               blk_rd_q;

  logic               ino_we;
  logic               blk_we;
  logic [BlkW-1:0]    blk_waddr;
  logic               blk_wdata;

  logic [CmpW-1:0]    nb_ext;
  logic [CmpW-1:0]    bound;
  logic               blk_more;
  logic               res_idx_zero;

  assign nb_ext   = CmpW'(num_blocks_q);
  assign bound    = (nb_ext > CmpW'(BLOCK_COUNT)) ? CmpW'(BLOCK_COUNT) : nb_ext;
  assign blk_more = CmpW'(ba_q) < bound;

  always_ff @(posedge clk_i) begin
    if (ino_we) begin
      ino_id_mem[free_idx_q]  <= id_q;
      ino_blk_mem[free_idx_q] <= bchk_idx_q;
    end
    ino_id_rd_q  <= ino_id_mem[ia_q[InoW-1:0]];
    ino_blk_rd_q <= ino_blk_mem[ia_q[InoW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rd_q <= blk_mem[ba_q[BlkW-1:0]];
  end

  always_comb begin
    state_d      = state_q;
    num_blocks_d = num_blocks_q;
    func_d       = func_q;
    id_d         = id_q;
    ia_d         = ia_q;
    ichk_v_d     = ichk_v_q;
    ichk_idx_d   = ichk_idx_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_blk_d  = match_blk_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    ba_d         = ba_q;
    bchk_v_d     = bchk_v_q;
    bchk_idx_d   = bchk_idx_q;
    in_use_d     = in_use_q;
    done_d       = 1'b0;
    status_d     = status_q;
    ino_d        = ino_q;
    blk_d        = blk_q;
    ino_we       = 1'b0;
    blk_we       = 1'b0;
    blk_waddr    = ba_q[BlkW-1:0];
    blk_wdata    = 1'b0;

    if (cfg_we_i) begin
      num_blocks_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_CLR: begin
        // blocks below the first data block start out reserved
        blk_we    = 1'b1;
        blk_wdata = ba_q < BlkCntW'(FirstDataBlk);
        ba_d      = ba_q + BlkCntW'(1);
        if (ba_q == BlkCntW'(BLOCK_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          func_d   = func_i;
          id_d     = file_id_i;
          ia_d     = '0;
          ichk_v_d = 1'b0;
          match_d  = 1'b0;
          free_d   = 1'b0;
          state_d  = S_INO;
        end
      end
      S_INO: begin
        if (ia_q != InoCntW'(INODE_COUNT)) begin
          ichk_v_d   = 1'b1;
          ichk_idx_d = ia_q[InoW-1:0];
          ia_d       = ia_q + InoCntW'(1);
        end else begin
          ichk_v_d = 1'b0;
        end
        if (ichk_v_q) begin
          if (in_use_q[ichk_idx_q]) begin
            if (!match_q && ino_id_rd_q == id_q) begin
              match_d     = 1'b1;
              match_idx_d = ichk_idx_q;
              match_blk_d = ino_blk_rd_q;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = ichk_idx_q;
          end
        end
        if (ia_q == InoCntW'(INODE_COUNT) && !ichk_v_q) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ST_NOT_FOUND;
          ino_d    = '0;
          blk_d    = '0;
          unique case (func_q)
            FN_CREATE: begin
              if (match_q) begin
                status_d = ST_EXISTS;
              end else if (!free_q) begin
                status_d = ST_NO_INODE;
              end else begin
                state_d  = S_BLK;
                done_d   = 1'b0;
                ba_d     = BlkCntW'(FirstDataBlk);
                bchk_v_d = 1'b0;
              end
            end
            FN_DELETE: begin
              if (match_q) begin
                status_d              = ST_OK;
                ino_d                 = InoOutW'(match_idx_q);
                blk_d                 = BlkOutW'(match_blk_q);
                in_use_d[match_idx_q] = 1'b0;
                blk_we                = 1'b1;
                blk_waddr             = match_blk_q;
                blk_wdata             = 1'b0;
              end
            end
            FN_LOOKUP: begin
              if (match_q) begin
                status_d = ST_OK;
                ino_d    = InoOutW'(match_idx_q);
                blk_d    = BlkOutW'(match_blk_q);
              end
            end
            default: ;
          endcase
        end
      end
      S_BLK: begin
        if (blk_more) begin
          bchk_v_d   = 1'b1;
          bchk_idx_d = ba_q[BlkW-1:0];
          ba_d       = ba_q + BlkCntW'(1);
        end else begin
          bchk_v_d = 1'b0;
        end
        if (bchk_v_q && !blk_rd_q) begin
          ino_we               = 1'b1;
          in_use_d[free_idx_q] = 1'b1;
          blk_we               = 1'b1;
          blk_waddr            = bchk_idx_q;
          blk_wdata            = 1'b1;
          status_d             = ST_OK;
          ino_d                = InoOutW'(free_idx_q);
          blk_d                = BlkOutW'(bchk_idx_q);
          done_d               = 1'b1;
          bchk_v_d             = 1'b0;
          state_d              = S_IDLE;
        end else if (!bchk_v_q && !blk_more) begin
          status_d = ST_NO_BLOCK;
          ino_d    = '0;
          blk_d    = '0;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      num_blocks_q <= NumBlkRst;
      ia_q         <= '0;
      ichk_v_q     <= 1'b0;
      match_q      <= 1'b0;
      free_q       <= 1'b0;
      ba_q         <= '0;
      bchk_v_q     <= 1'b0;
      in_use_q     <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      num_blocks_q <= num_blocks_d;
      ia_q         <= ia_d;
      ichk_v_q     <= ichk_v_d;
      match_q      <= match_d;
      free_q       <= free_d;
      ba_q         <= ba_d;
      bchk_v_q     <= bchk_v_d;
      in_use_q     <= in_use_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    id_q        <= id_d;
    ichk_idx_q  <= ichk_idx_d;
    match_idx_q <= match_idx_d;
    match_blk_q <= match_blk_d;
    free_idx_q  <= free_idx_d;
    bchk_idx_q  <= bchk_idx_d;
    status_q    <= status_d;
    ino_q       <= ino_d;
    blk_q       <= blk_d;
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign inode_index_o = ino_q;
  assign block_index_o = blk_q;

  assign res_idx_zero = inode_index_o == '0 && block_index_o == '0;

  `include "assert_macros.svh"

  `IBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after a request transfer")
  `IBA_ASSERT(a_fail_zero, done_o && status_o != ST_OK |-> res_idx_zero, "nonzero index on failure")
  `IBA_ASSERT(a_blk_scan_free, state_q == S_BLK |-> free_q && !match_q, "block scan, no free inode")
  `IBA_ASSERT(a_done_after_busy, done_o |-> $past(busy), "strobe without request in flight")

endmodule

`default_nettype wire
